### rtl/bdgd_pkg.sv
`default_nettype none

package bdgd_pkg;

  // Request kinds carried on the input tuser
  localparam logic [1:0] REQ_INIT   = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_TAKE   = 2'd2;

  // Gesture codes on the result
  localparam logic [1:0] GEST_NONE   = 2'd0;
  localparam logic [1:0] GEST_SHORT  = 2'd1;
  localparam logic [1:0] GEST_LONG   = 2'd2;
  localparam logic [1:0] GEST_DOUBLE = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_PRESS_HIGH    = 3'd0;
  localparam logic [2:0] REG_DOUBLE_ENABLE = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE_MS   = 3'd2;
  localparam logic [2:0] REG_HOLD_LIMIT_MS = 3'd3;
  localparam logic [2:0] REG_GAP_WINDOW_MS = 3'd4;

  // Register reset values
  localparam logic        RST_PRESS_HIGH    = 1'b1;
  localparam logic        RST_DOUBLE_ENABLE = 1'b0;
  localparam logic [15:0] RST_DEBOUNCE_MS   = 16'd20;
  localparam logic [15:0] RST_HOLD_LIMIT_MS = 16'd600;
  localparam logic [15:0] RST_GAP_WINDOW_MS = 16'd300;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

endpackage

`default_nettype wire

### rtl/button_debounce_gesture_detector_unit.sv
`default_nettype none

// Button debounce and gesture detector.
// Path: input register, then result register.
// Throughput: one item per cycle while the result side accepts; the state update
// is one pass of compare/add logic between the input register and the result register.
// Reset (rst_ni, async, active low): registers to defaults, all tracking state
// and pending gestures cleared, both stream stages empty.
module button_debounce_gesture_detector_unit
  import bdgd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [0] pin_level, [32:1] now_ms, rest 0
  input  wire logic [1:0]            s_axis_tuser,  // [1:0] req_type
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // [0] stable_level, [2:1] gesture, rest 0
  // register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        press_high_q;
  logic        double_enable_q;
  logic [15:0] debounce_ms_q;
  logic [15:0] hold_limit_ms_q;
  logic [15:0] gap_window_ms_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_high_q    <= RST_PRESS_HIGH;
      double_enable_q <= RST_DOUBLE_ENABLE;
      debounce_ms_q   <= RST_DEBOUNCE_MS;
      hold_limit_ms_q <= RST_HOLD_LIMIT_MS;
      gap_window_ms_q <= RST_GAP_WINDOW_MS;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PRESS_HIGH:    press_high_q    <= pwdata[0];
        REG_DOUBLE_ENABLE: double_enable_q <= pwdata[0];
        REG_DEBOUNCE_MS:   debounce_ms_q   <= pwdata[15:0];
        REG_HOLD_LIMIT_MS: hold_limit_ms_q <= pwdata[15:0];
        REG_GAP_WINDOW_MS: gap_window_ms_q <= pwdata[15:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PRESS_HIGH:    prdata = {31'd0, press_high_q};
      REG_DOUBLE_ENABLE: prdata = {31'd0, double_enable_q};
      REG_DEBOUNCE_MS:   prdata = {16'd0, debounce_ms_q};
      REG_HOLD_LIMIT_MS: prdata = {16'd0, hold_limit_ms_q};
      REG_GAP_WINDOW_MS: prdata = {16'd0, gap_window_ms_q};
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stream handshake: input register feeds the update pass, which writes the
  // result register. The result register frees up in the cycle its transfer
  // completes, so items flow back to back while the result side accepts; a
  // waiting result lets at most one more item into the input register.
  // ---------------------------------------------------------------------------
  logic              in_valid_q;
  logic [1:0]        req_q;
  logic              pin_q;
  logic [TIME_W-1:0] now_q;
  logic              out_valid_q;
  logic              res_stable_q;
  logic [1:0]        res_gesture_q;
  logic              out_free;
  logic              step;

  assign out_free      = ~out_valid_q | m_axis_tready;
  assign step          = in_valid_q & out_free;
  assign s_axis_tready = ~in_valid_q | out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_q <= s_axis_tuser;
      pin_q <= s_axis_tdata[0];
      now_q <= s_axis_tdata[TIME_W:1];
    end
  end

  // ---------------------------------------------------------------------------
  // Tracking state
  // ---------------------------------------------------------------------------
  logic              cand_q, cand_d;
  logic              stable_q, stable_d;
  logic              prev_q, prev_d;
  logic [TIME_W-1:0] raw_chg_q, raw_chg_d;
  logic [TIME_W-1:0] press_q, press_d;
  logic [TIME_W-1:0] deadline_q, deadline_d;
  logic              suppress_q, suppress_d;
  logic              long_done_q, long_done_d;
  logic              short_pend_q, short_pend_d;
  logic              long_pend_q, long_pend_d;
  logic              dbl_pend_q, dbl_pend_d;
  logic [1:0]        gesture_d;

  logic              raw;
  logic [TIME_W-1:0] since_raw;
  logic [TIME_W-1:0] to_deadline;
  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] past_deadline;
  logic              in_window;

  // pressed level after polarity
  assign raw = pin_q ^ ~press_high_q;

  always_comb begin
    cand_d       = cand_q;
    stable_d     = stable_q;
    prev_d       = prev_q;
    raw_chg_d    = raw_chg_q;
    press_d      = press_q;
    deadline_d   = deadline_q;
    suppress_d   = suppress_q;
    long_done_d  = long_done_q;
    short_pend_d = short_pend_q;
    long_pend_d  = long_pend_q;
    dbl_pend_d   = dbl_pend_q;
    gesture_d    = GEST_NONE;

    since_raw     = '0;
    to_deadline   = '0;
    held          = '0;
    past_deadline = '0;
    in_window     = 1'b0;

    unique case (req_q)
      REQ_INIT: begin
        cand_d    = raw;
        stable_d  = raw;
        prev_d    = raw;
        raw_chg_d = now_q;
      end
      REQ_SAMPLE: begin
        // raw level tracking
        if (raw != cand_q) begin
          cand_d    = raw;
          raw_chg_d = now_q;
        end
        since_raw = now_q - raw_chg_d;
        if (cand_d != stable_q && since_raw >= {16'd0, debounce_ms_q}) begin
          stable_d = cand_d;
        end

        // press / release edges
        to_deadline = now_q - deadline_q;
        in_window   = (deadline_q != '0) && (to_deadline[TIME_W-1] || now_q == deadline_q);
        if (stable_d && !prev_q) begin
          if (double_enable_q && in_window) begin
            deadline_d = '0;
            suppress_d = 1'b1;
            dbl_pend_d = 1'b1;
          end else begin
            suppress_d = 1'b0;
          end
          press_d     = now_q;
          long_done_d = 1'b0;
        end else if (!stable_d && prev_q) begin
          if (!suppress_q && !long_done_q) begin
            if (double_enable_q) begin
              deadline_d = now_q + {16'd0, gap_window_ms_q};
            end else begin
              short_pend_d = 1'b1;
            end
          end
        end

        // long hold
        held = now_q - press_d;
        if (stable_d && !long_done_d && held >= {16'd0, hold_limit_ms_q}) begin
          long_done_d = 1'b1;
          long_pend_d = 1'b1;
        end

        // gap window expiry releases a delayed short press
        past_deadline = now_q - deadline_d;
        if (deadline_d != '0 && !past_deadline[TIME_W-1]) begin
          deadline_d   = '0;
          short_pend_d = 1'b1;
        end

        prev_d = stable_d;
      end
      REQ_TAKE: begin
        priority if (long_pend_q) begin
          long_pend_d = 1'b0;
          gesture_d   = GEST_LONG;
        end else if (dbl_pend_q) begin
          dbl_pend_d = 1'b0;
          gesture_d  = GEST_DOUBLE;
        end else if (short_pend_q) begin
          short_pend_d = 1'b0;
          gesture_d    = GEST_SHORT;
        end else begin
          gesture_d = GEST_NONE;
        end
      end
      default: ;  // unused request code: no change
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q       <= 1'b0;
      stable_q     <= 1'b0;
      prev_q       <= 1'b0;
      raw_chg_q    <= '0;
      press_q      <= '0;
      deadline_q   <= '0;
      suppress_q   <= 1'b0;
      long_done_q  <= 1'b0;
      short_pend_q <= 1'b0;
      long_pend_q  <= 1'b0;
      dbl_pend_q   <= 1'b0;
    end else if (step) begin
      cand_q       <= cand_d;
      stable_q     <= stable_d;
      prev_q       <= prev_d;
      raw_chg_q    <= raw_chg_d;
      press_q      <= press_d;
      deadline_q   <= deadline_d;
      suppress_q   <= suppress_d;
      long_done_q  <= long_done_d;
      short_pend_q <= short_pend_d;
      long_pend_q  <= long_pend_d;
      dbl_pend_q   <= dbl_pend_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_stable_q  <= stable_d;
      res_gesture_q <= gesture_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-3){1'b0}}, res_gesture_q, res_stable_q};

endmodule

`default_nettype wire
